### rtl/core/cid_pkg.sv
// Shared types and constants for the compact index decoder.
// Used by every module of the core; depends on nothing else.
`default_nettype none

package cid_pkg;

   // Field widths.
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned ValueWidth = 32;
   localparam int unsigned MagWidth   = 31;
   localparam int unsigned CountWidth = 3;
   localparam int unsigned StatWidth  = 2;

   // Stream bus widths (tdata padded to whole bytes).
   localparam int unsigned ReqDataWidth = 8;
   localparam int unsigned RspDataWidth = 40;

   // Highest byte count of one value, and the last payload limit.
   localparam logic [CountWidth-1:0] MaxBytes     = 3'd5;
   localparam logic [6:0]            LastByteMax  = 7'h0f;

   // Result status codes.
   typedef enum logic [StatWidth-1:0] {
      STAT_OK        = 2'd0,
      STAT_OVERFLOW  = 2'd1,
      STAT_OVERLONG  = 2'd2,
      STAT_TRUNCATED = 2'd3
   } status_type;

   // One input byte with its end-of-buffer mark.
   typedef struct packed {
      logic                 buffer_end;
      logic [ByteWidth-1:0] data_byte;
   } item_type;

   // One decoded result.
   typedef struct packed {
      status_type                    status;
      logic [CountWidth-1:0]         byte_count;
      logic signed [ValueWidth-1:0]  decoded_value;
   } result_type;

endpackage

`default_nettype wire

### rtl/core/cid_in_reg.sv
// Input register of the compact index decoder: holds one request byte.
// Depends on cid_pkg.
`default_nettype none

module cid_in_reg (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [cid_pkg::ReqDataWidth-1:0] req_tdata,
   input  wire logic                           req_tlast,
   input  wire logic                           advance,
   output logic                                item_valid,
   output cid_pkg::item_type                   item
);

   logic              valid_ff;
   logic              valid_in;
   cid_pkg::item_type item_ff;
   logic              take;

   // A new request enters when the register is empty or drains this cycle.
   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.data_byte  <= req_tdata[cid_pkg::ByteWidth-1:0];
         item_ff.buffer_end <= req_tlast;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

### rtl/core/cid_decode.sv
// Decode step of the compact index decoder: pending-value state and the
// per-byte accumulate, sign and error logic. Depends on cid_pkg.
`default_nettype none

module cid_decode (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                item_valid,
   input  wire cid_pkg::item_type   item,
   input  wire logic                advance,
   output logic                     result_valid,
   output cid_pkg::result_type      result
);

   logic [cid_pkg::MagWidth-1:0]   mag_ff, mag_in;
   logic [cid_pkg::CountWidth-1:0] seen_ff, seen_in;
   logic                           sign_ff, sign_in;

   logic [cid_pkg::MagWidth-1:0]   mag_new;
   logic [cid_pkg::MagWidth-1:0]   shifted;
   logic [6:0]                     payload;
   logic [cid_pkg::CountWidth-1:0] count;
   logic                           sign_new;
   logic                           first;
   logic                           emit;
   logic [cid_pkg::ValueWidth-1:0] mag_ext;

   assign payload = item.data_byte[6:0];
   assign first   = (seen_ff == '0) || (seen_ff >= cid_pkg::MaxBytes);
   assign count   = first ? 3'd1 : seen_ff + 3'd1;

   // Place a continuation payload at 6, 13, 20 or 27 bits.
   always_comb begin
      unique case (seen_ff)
         3'd1:    shifted = {18'd0, payload, 6'd0};
         3'd2:    shifted = {11'd0, payload, 13'd0};
         3'd3:    shifted = {4'd0, payload, 20'd0};
         default: shifted = {payload[3:0], 27'd0};
      endcase
   end

   // Work out the result and the next pending state for this byte.
   always_comb begin
      emit                 = 1'b0;
      result.status        = cid_pkg::STAT_OK;
      result.byte_count    = count;
      sign_new             = sign_ff;
      mag_new              = mag_ff;
      if (first) begin
         sign_new = item.data_byte[7];
         mag_new  = {25'd0, item.data_byte[5:0]};
         if (!item.data_byte[6]) begin
            emit = 1'b1;
         end else if (item.buffer_end) begin
            emit          = 1'b1;
            result.status = cid_pkg::STAT_TRUNCATED;
         end
      end else begin
         mag_new = mag_ff | shifted;
         if (seen_ff == 3'd4 && payload > cid_pkg::LastByteMax) begin
            emit          = 1'b1;
            result.status = cid_pkg::STAT_OVERFLOW;
         end else if (!item.data_byte[7]) begin
            emit = 1'b1;
         end else if (count >= cid_pkg::MaxBytes) begin
            emit          = 1'b1;
            result.status = cid_pkg::STAT_OVERLONG;
         end else if (item.buffer_end) begin
            emit          = 1'b1;
            result.status = cid_pkg::STAT_TRUNCATED;
         end
      end

      // Apply the sign; every error carries a zero value.
      mag_ext = {1'b0, mag_new};
      if (result.status != cid_pkg::STAT_OK) begin
         result.decoded_value = '0;
      end else if (sign_new) begin
         result.decoded_value = -mag_ext;
      end else begin
         result.decoded_value = mag_ext;
      end
   end

   assign result_valid = item_valid && emit;

   // Any result clears the pending value; otherwise keep gathering.
   always_comb begin
      mag_in  = mag_ff;
      seen_in = seen_ff;
      sign_in = sign_ff;
      if (item_valid && advance) begin
         if (emit) begin
            mag_in  = '0;
            seen_in = '0;
            sign_in = 1'b0;
         end else begin
            mag_in  = mag_new;
            seen_in = count;
            sign_in = sign_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_ff  <= '0;
         seen_ff <= '0;
         sign_ff <= 1'b0;
      end else begin
         mag_ff  <= mag_in;
         seen_ff <= seen_in;
         sign_ff <= sign_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/cid_out_reg.sv
// Output register of the compact index decoder: holds one result until the
// response side takes it. Depends on cid_pkg.
`default_nettype none

module cid_out_reg (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           load,
   input  wire cid_pkg::result_type            result,
   output logic                                out_free,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [cid_pkg::RspDataWidth-1:0]    rsp_tdata,
   output logic [cid_pkg::StatWidth-1:0]       rsp_tuser
);

   logic                valid_ff, valid_in;
   cid_pkg::result_type result_ff;

   // The register can take a result when empty or being read this cycle.
   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   // Pack value and count into tdata, zero padded to whole bytes.
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {5'd0, result_ff.byte_count, result_ff.decoded_value};
   assign rsp_tuser  = result_ff.status;

endmodule

`default_nettype wire

### rtl/core/compact_index_decoder_core.sv
// Compact index decoder: takes one encoded byte per request and returns one
// response each time a signed value completes or an error is found. A new
// byte is accepted every clock cycle unless the input register is stalled;
// the byte is held in the input register and its response in the output
// register, which presents it on the response side.
// Back-pressure on the response side stalls a byte that would produce a response
// while the output register is full and not read, and new requests behind it.
`default_nettype none

module compact_index_decoder_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // [7:0] data_byte
   input  wire logic [cid_pkg::ReqDataWidth-1:0] req_tdata,
   // buffer_end
   input  wire logic                           req_tlast,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // [31:0] decoded_value, [34:32] byte_count, [39:35] zero
   output logic [cid_pkg::RspDataWidth-1:0]    rsp_tdata,
   // [1:0] status
   output logic [cid_pkg::StatWidth-1:0]       rsp_tuser
);

   logic                item_valid;
   cid_pkg::item_type   item;
   logic                result_valid;
   cid_pkg::result_type result;
   logic                out_free;
   logic                advance;

   // A byte leaves the input register unless its response cannot be stored.
   assign advance = item_valid && (!result_valid || out_free);

   cid_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   cid_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (item_valid),
      .item         (item),
      .advance      (advance),
      .result_valid (result_valid),
      .result       (result)
   );

   cid_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && result_valid),
      .result     (result),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

### rtl/core/cid_checker.sv
// Port-level checks for the compact index decoder, bound to the top level.
// Depends on cid_pkg and compact_index_decoder_core.
`default_nettype none

module cid_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tready,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [cid_pkg::RspDataWidth-1:0] rsp_tdata,
   input wire logic [cid_pkg::StatWidth-1:0]  rsp_tuser
);

   // A stalled response holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // Errors carry a zero value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != cid_pkg::STAT_OK |-> rsp_tdata[31:0] == 32'd0)
      else $error("error response with nonzero value");

   // Byte count stays within one to five, and the padding above it is zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[34:32] != 3'd0 && rsp_tdata[34:32] <= cid_pkg::MaxBytes
                     && rsp_tdata[39:35] == 5'd0)
      else $error("byte count out of range");

   // Overflow and overlong only happen on the fifth byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == cid_pkg::STAT_OVERFLOW
                     || rsp_tuser == cid_pkg::STAT_OVERLONG)
      |-> rsp_tdata[34:32] == cid_pkg::MaxBytes)
      else $error("fifth-byte error with wrong count");

   // Nothing is pending right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not empty after reset");

endmodule

bind compact_index_decoder_core cid_checker u_cid_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
